### rtl/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg
// Shared constants for the sum-checked frame deframer: buffer geometry,
// register indexes, drop codes and stream widths.
// ----------------------------------------------------------------------------
package scfd_pkg;

	// frame byte store
	localparam int BUF_BYTES = 512;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	localparam int WP_W      = ADDR_W + 1;

	// frame layout
	localparam int HDR_BYTES  = 11;
	localparam int DATA_HEAD  = 10;
	localparam int ADDR_BYTES = 6;
	localparam int RIDX_W     = 9;
	// payload read position: header offset plus read index
	localparam int POS_W      = ((ADDR_W > RIDX_W) ? ADDR_W : RIDX_W) + 1;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 9;
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 2'd2;
	localparam logic [7:0] START_BYTE_RST = 8'h68;
	localparam logic [7:0] END_BYTE_RST   = 8'h16;
	localparam logic [8:0] MAX_LEN_RST    = 9'd501;

	// drop reasons
	localparam logic [2:0] DROP_NONE   = 3'd0;
	localparam logic [2:0] DROP_START2 = 3'd1;
	localparam logic [2:0] DROP_LEN    = 3'd2;
	localparam logic [2:0] DROP_SUM    = 3'd3;
	localparam logic [2:0] DROP_END    = 3'd4;
	localparam logic [2:0] DROP_OVF    = 3'd5;

	// opcodes
	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	// stream widths
	localparam int IN_W  = 24;
	localparam int RES_W = 157;
	localparam int OUT_W = 160;

endpackage

### rtl/sum_checked_frame_deframer.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer
// Byte-serial parser for sum-checked link frames with a payload byte store.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): one transaction per byte. s_tuser is the opcode:
//   feed carries a received byte in s_tdata, read carries a payload index.
//   Output stream (m_*): exactly one result transaction per input
//   transaction, in order: frame_done, drop_reason, header fields of a good
//   frame, and the buffered payload byte for a read.
//   Frame bytes are written to a 512-byte synchronous RAM as they arrive;
//   header fields are also latched in registers and reported on the end byte.
//   The parse step and the RAM read are registered first, and the result
//   is then registered in the output register.
//   Throughput is one transaction per cycle while m_tready stays high; the
//   RAM's single write and single read port take one byte each cycle.
//   When m_tready is low the result waits in the output register, one more
//   item waits in the parse stage, and s_tready drops after that.
//   Reset returns the parser to hunting and loads the register defaults;
//   the byte store is not cleared, so reads are meaningful only for
//   positions written by an earlier frame.
//   Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once
//   and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [scfd_pkg::IN_W-1:0]     s_tdata,  // rx_byte[7:0], read_index[16:8]
	input  logic                          s_tuser,  // opcode
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_done[0], drop_reason[3:1], station_addr[51:4], ctrl_code[59:52],
	// time_stamp[107:60], device_kind[115:108], data_id[131:116],
	// seq_num[139:132], body_bytes[148:140], read_data[156:149]
	output logic [scfd_pkg::OUT_W-1:0]    m_tdata,
	// configuration
	input  logic                          cfg_we,
	input  logic [scfd_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [scfd_pkg::CFG_W-1:0]    cfg_wdata
);

	// parser phases
	localparam logic [3:0] PH_HUNT   = 4'd0;
	localparam logic [3:0] PH_ADDR   = 4'd1;
	localparam logic [3:0] PH_START2 = 4'd2;
	localparam logic [3:0] PH_CTRL   = 4'd3;
	localparam logic [3:0] PH_LEN_LO = 4'd4;
	localparam logic [3:0] PH_LEN_HI = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_SUM    = 4'd7;
	localparam logic [3:0] PH_END    = 4'd8;

	localparam int ADDR_W = scfd_pkg::ADDR_W;
	localparam int WP_W   = scfd_pkg::WP_W;
	localparam int POS_W  = scfd_pkg::POS_W;

	// configuration registers
	logic [7:0] start_byte_q;
	logic [7:0] end_byte_q;
	logic [8:0] max_len_q;

	// parser state
	logic [3:0]      phase_q, phase_n;
	logic [2:0]      addr_idx_q, addr_idx_n;
	logic [8:0]      body_count_q, body_count_n;
	logic [8:0]      body_len_q, body_len_n;
	logic [7:0]      sum_q, sum_n;
	logic [WP_W-1:0] wpos_q, wpos_n;

	// header shadow registers
	logic [47:0] addr_q;
	logic [7:0]  ctrl_q;
	logic [47:0] time_q;
	logic [7:0]  dev_q;
	logic [15:0] id_q;
	logic [7:0]  seq_q;

	// parse stage
	logic       valid_s1;
	logic       done_s1;
	logic [2:0] drop_s1;
	logic       read_s1;
	logic       oob_s1;
	logic [8:0] plen_s1;

	// output register
	logic               out_valid_q;
	logic [scfd_pkg::RES_W-1:0] out_q;

	// step results
	logic       done_n;
	logic [2:0] drop_n;
	logic       we;
	logic       re;
	logic [ADDR_W-1:0] raddr;
	logic [POS_W-1:0]  rpos;
	logic       oob_n;
	logic [7:0] rdata;
	logic       accept;
	logic       advance;
	logic       ovf;
	logic [7:0] rx_byte;
	logic [8:0] read_index;
	logic [8:0] len_full;
	logic       len_bad;
	logic [9:0] body_count_inc;

	assign rx_byte    = s_tdata[7:0];
	assign read_index = s_tdata[16:8];

	// handshakes
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(scfd_pkg::OUT_W - scfd_pkg::RES_W){1'b0}}, out_q};

	// overflow when the next store position is past the buffer
	assign ovf = (wpos_q >= WP_W'(scfd_pkg::BUF_BYTES));

	// length check on the high byte
	assign len_full       = {rx_byte[0], body_len_q[7:0]};
	assign len_bad        = (rx_byte[7:1] != 7'd0) ||
	                        (len_full < 9'(scfd_pkg::DATA_HEAD)) ||
	                        (len_full > max_len_q);
	assign body_count_inc = {1'b0, body_count_q} + 10'd1;

	// payload read address
	assign rpos  = POS_W'(scfd_pkg::HDR_BYTES + scfd_pkg::DATA_HEAD) +
	               POS_W'(read_index);
	assign oob_n = (rpos >= POS_W'(scfd_pkg::BUF_BYTES));
	assign raddr = rpos[ADDR_W-1:0];
	assign re    = accept && (s_tuser == scfd_pkg::OP_READ) && !oob_n;

	// parser next state for a feed transaction
	always_comb begin
		phase_n      = phase_q;
		addr_idx_n   = addr_idx_q;
		body_count_n = body_count_q;
		body_len_n   = body_len_q;
		sum_n        = sum_q;
		wpos_n       = wpos_q;
		done_n       = 1'b0;
		drop_n       = scfd_pkg::DROP_NONE;
		we           = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == start_byte_q) begin
					we         = 1'b1;
					wpos_n     = WP_W'(1);
					sum_n      = rx_byte;
					addr_idx_n = 3'd0;
					phase_n    = PH_ADDR;
				end
			end
			PH_ADDR, PH_CTRL, PH_LEN_LO, PH_LEN_HI, PH_DATA: begin
				if (ovf) begin
					drop_n  = scfd_pkg::DROP_OVF;
					phase_n = PH_HUNT;
				end else begin
					we     = 1'b1;
					wpos_n = wpos_q + WP_W'(1);
					sum_n  = sum_q + rx_byte;
					case (phase_q)
						PH_ADDR: begin
							addr_idx_n = addr_idx_q + 3'd1;
							if (addr_idx_q == 3'(scfd_pkg::ADDR_BYTES - 1)) begin
								phase_n = PH_START2;
							end
						end
						PH_CTRL: begin
							phase_n = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							body_len_n = {1'b0, rx_byte};
							phase_n    = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							body_len_n   = len_full;
							body_count_n = 9'd0;
							if (len_bad) begin
								drop_n  = scfd_pkg::DROP_LEN;
								phase_n = PH_HUNT;
							end else begin
								phase_n = PH_DATA;
							end
						end
						default: begin
							body_count_n = body_count_inc[8:0];
							if (body_count_inc >= {1'b0, body_len_q}) begin
								phase_n = PH_SUM;
							end
						end
					endcase
				end
			end
			PH_START2: begin
				if (rx_byte != start_byte_q) begin
					drop_n  = scfd_pkg::DROP_START2;
					phase_n = PH_HUNT;
				end else if (ovf) begin
					drop_n  = scfd_pkg::DROP_OVF;
					phase_n = PH_HUNT;
				end else begin
					we      = 1'b1;
					wpos_n  = wpos_q + WP_W'(1);
					sum_n   = sum_q + rx_byte;
					phase_n = PH_CTRL;
				end
			end
			PH_SUM: begin
				if (rx_byte != sum_q) begin
					drop_n  = scfd_pkg::DROP_SUM;
					phase_n = PH_HUNT;
				end else begin
					phase_n = PH_END;
				end
			end
			PH_END: begin
				if (rx_byte == end_byte_q) begin
					done_n = 1'b1;
				end else begin
					drop_n = scfd_pkg::DROP_END;
				end
				phase_n = PH_HUNT;
			end
			default: begin
				phase_n = PH_HUNT;
			end
		endcase
		// any return to hunting clears the frame counters
		if (phase_n == PH_HUNT) begin
			addr_idx_n   = 3'd0;
			body_count_n = 9'd0;
			body_len_n   = 9'd0;
			sum_n        = 8'd0;
			wpos_n       = '0;
		end
	end

	// frame byte store
	scfd_ram #(
		.WIDTH (8),
		.DEPTH (scfd_pkg::BUF_BYTES)
	) u_store (
		.clk   (clk),
		.we    (accept && (s_tuser == scfd_pkg::OP_FEED) && we),
		.waddr (wpos_q[ADDR_W-1:0]),
		.wdata (rx_byte),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= scfd_pkg::START_BYTE_RST;
			end_byte_q   <= scfd_pkg::END_BYTE_RST;
			max_len_q    <= scfd_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				scfd_pkg::REG_START_BYTE: start_byte_q <= cfg_wdata[7:0];
				scfd_pkg::REG_END_BYTE:   end_byte_q   <= cfg_wdata[7:0];
				scfd_pkg::REG_MAX_LEN:    max_len_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			addr_idx_q   <= 3'd0;
			body_count_q <= 9'd0;
			body_len_q   <= 9'd0;
			sum_q        <= 8'd0;
			wpos_q       <= '0;
		end else if (accept && (s_tuser == scfd_pkg::OP_FEED)) begin
			phase_q      <= phase_n;
			addr_idx_q   <= addr_idx_n;
			body_count_q <= body_count_n;
			body_len_q   <= body_len_n;
			sum_q        <= sum_n;
			wpos_q       <= wpos_n;
		end
	end

	// header shadow capture at the store position of each header byte
	always_ff @(posedge clk) begin
		if (accept && (s_tuser == scfd_pkg::OP_FEED) && we) begin
			for (int i = 0; i < scfd_pkg::ADDR_BYTES; i++) begin
				if (wpos_q == WP_W'(1 + i)) begin
					addr_q[8*i +: 8] <= rx_byte;
				end
				if (wpos_q == WP_W'(scfd_pkg::HDR_BYTES + i)) begin
					time_q[8*i +: 8] <= rx_byte;
				end
			end
			if (wpos_q == WP_W'(8)) begin
				ctrl_q <= rx_byte;
			end
			if (wpos_q == WP_W'(scfd_pkg::HDR_BYTES + 6)) begin
				dev_q <= rx_byte;
			end
			if (wpos_q == WP_W'(scfd_pkg::HDR_BYTES + 7)) begin
				id_q[15:8] <= rx_byte;
			end
			if (wpos_q == WP_W'(scfd_pkg::HDR_BYTES + 8)) begin
				id_q[7:0] <= rx_byte;
			end
			if (wpos_q == WP_W'(scfd_pkg::HDR_BYTES + 9)) begin
				seq_q <= rx_byte;
			end
		end
	end

	// parse stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload length is taken before the end byte clears the frame length
	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1 <= (s_tuser == scfd_pkg::OP_READ);
			oob_s1  <= oob_n;
			done_s1 <= (s_tuser == scfd_pkg::OP_FEED) && done_n;
			drop_s1 <= (s_tuser == scfd_pkg::OP_FEED) ? drop_n : scfd_pkg::DROP_NONE;
			plen_s1 <= body_len_q - 9'(scfd_pkg::DATA_HEAD);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result assembly; header fields only on a completed frame
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q[0]       <= done_s1;
			out_q[3:1]     <= drop_s1;
			out_q[51:4]    <= done_s1 ? addr_q : 48'd0;
			out_q[59:52]   <= done_s1 ? ctrl_q : 8'd0;
			out_q[107:60]  <= done_s1 ? time_q : 48'd0;
			out_q[115:108] <= done_s1 ? dev_q : 8'd0;
			out_q[131:116] <= done_s1 ? id_q : 16'd0;
			out_q[139:132] <= done_s1 ? seq_q : 8'd0;
			out_q[148:140] <= done_s1 ? plen_s1 : 9'd0;
			out_q[156:149] <= (read_s1 && !oob_s1) ? rdata : 8'd0;
		end
	end

endmodule

### rtl/scfd_ram.sv
// ----------------------------------------------------------------------------
// scfd_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module scfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/scfd_checker.sv
// ----------------------------------------------------------------------------
// scfd_checker
// Port-level assertions for the sum-checked frame deframer, bound to the
// top level.
// ----------------------------------------------------------------------------
module scfd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [scfd_pkg::OUT_W-1:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a completed frame carries no drop reason and no read byte
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |->
			(m_tdata[3:1] == scfd_pkg::DROP_NONE) && (m_tdata[156:149] == 8'd0))
		else $error("completed frame with drop reason or read data");

	// header fields stay zero unless a frame completed
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[148:4] == '0))
		else $error("header fields set without a completed frame");

	// drop reason is a known code
	a_drop_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:1] <= scfd_pkg::DROP_OVF))
		else $error("unknown drop reason");

endmodule

bind sum_checked_frame_deframer scfd_checker u_scfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/sum_checked_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_deframer_tb
// Self-checking bench for the frame deframer. Feed and read transactions go
// in on the input stream. A behavioral parser inside the bench predicts each
// result transaction, and the output stream is compared with it field by
// field. The run covers directed frames, drops and store reads, then random
// traffic under several register settings and throttling modes.
// ----------------------------------------------------------------------------
module sum_checked_frame_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		S_HUNT, S_ADDR, S_DELIM2, S_CTRL, S_LEN_LO, S_LEN_HI, S_DATA, S_SUM, S_TAIL
	} parse_phase_t;

	typedef enum int {FLAW_NONE, FLAW_START2, FLAW_LEN, FLAW_SUM, FLAW_END} frame_flaw_t;
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} frame_fill_t;

	// same bit order as m_tdata[RES_W-1:0]
	typedef struct packed {
		logic [7:0]  rdata;
		logic [8:0]  plen;
		logic [7:0]  seq;
		logic [15:0] id;
		logic [7:0]  dev;
		logic [47:0] stamp;
		logic [7:0]  ctrl;
		logic [47:0] addr;
		logic [2:0]  drop;
		logic        done;
	} frame_result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [scfd_pkg::IN_W-1:0]      s_tdata   = '0;
	logic                           s_tuser   = scfd_pkg::OP_FEED;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [scfd_pkg::OUT_W-1:0]     m_tdata;
	logic                           cfg_we    = 1'b0;
	logic [scfd_pkg::CFG_IDX_W-1:0] cfg_addr  = scfd_pkg::REG_START_BYTE;
	logic [scfd_pkg::CFG_W-1:0]     cfg_wdata = '0;

	// parser shadow: registers, state and byte store
	logic [7:0]   start_q    = scfd_pkg::START_BYTE_RST;
	logic [7:0]   end_q      = scfd_pkg::END_BYTE_RST;
	logic [8:0]   max_len_q  = scfd_pkg::MAX_LEN_RST;
	parse_phase_t phase_q    = S_HUNT;
	logic [2:0]   addr_idx   = '0;
	logic [15:0]  body_count = '0;
	logic [15:0]  body_len   = '0;
	logic [7:0]   sum_q      = '0;
	logic [9:0]   wr_pos     = '0;
	logic [7:0]   shadow_store [scfd_pkg::BUF_BYTES];
	// entries below this position have been written at least once
	int unsigned  store_fill = 0;

	frame_result_t parse_results_due [$];
	int unsigned   error_count    = 0;
	int unsigned   item_count     = 0;
	int unsigned   send_gap_pct   = 0;
	int unsigned   recv_stall_pct = 0;

	sum_checked_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// parser prediction
	// ------------------------------------------------------------------
	function automatic void restart_hunt();
		phase_q    = S_HUNT;
		addr_idx   = '0;
		body_count = '0;
		body_len   = '0;
		sum_q      = '0;
		wr_pos     = '0;
	endfunction

	// store a frame byte and add it to the sum; 0 means overflow
	function automatic bit keep_byte(logic [7:0] b);
		if (wr_pos >= scfd_pkg::BUF_BYTES) begin
			restart_hunt();
			return 1'b0;
		end
		shadow_store[wr_pos] = b;
		wr_pos = wr_pos + 10'd1;
		sum_q  = sum_q + b;
		if (wr_pos > store_fill)
			store_fill = wr_pos;
		return 1'b1;
	endfunction

	function automatic frame_result_t parse_byte(logic op, logic [7:0] b, logic [8:0] idx);
		frame_result_t r;
		int unsigned pos;
		r = '0;
		if (op == scfd_pkg::OP_READ) begin
			pos = scfd_pkg::HDR_BYTES + scfd_pkg::DATA_HEAD + idx;
			if (pos < scfd_pkg::BUF_BYTES)
				r.rdata = shadow_store[pos];
			return r;
		end
		case (phase_q)
			S_HUNT: begin
				if (b == start_q) begin
					wr_pos = '0;
					sum_q  = '0;
					void'(keep_byte(b));
					addr_idx = '0;
					phase_q  = S_ADDR;
				end
			end
			S_ADDR: begin
				if (!keep_byte(b)) begin
					r.drop = scfd_pkg::DROP_OVF;
				end else begin
					addr_idx = addr_idx + 3'd1;
					if (addr_idx >= scfd_pkg::ADDR_BYTES)
						phase_q = S_DELIM2;
				end
			end
			S_DELIM2: begin
				if (b != start_q) begin
					restart_hunt();
					r.drop = scfd_pkg::DROP_START2;
				end else if (!keep_byte(b)) begin
					r.drop = scfd_pkg::DROP_OVF;
				end else begin
					phase_q = S_CTRL;
				end
			end
			S_CTRL: begin
				if (!keep_byte(b))
					r.drop = scfd_pkg::DROP_OVF;
				else
					phase_q = S_LEN_LO;
			end
			S_LEN_LO: begin
				if (!keep_byte(b)) begin
					r.drop = scfd_pkg::DROP_OVF;
				end else begin
					body_len = {8'h00, b};
					phase_q  = S_LEN_HI;
				end
			end
			S_LEN_HI: begin
				if (!keep_byte(b)) begin
					r.drop = scfd_pkg::DROP_OVF;
				end else begin
					body_len = {b, body_len[7:0]};
					if (body_len < scfd_pkg::DATA_HEAD || body_len > max_len_q) begin
						restart_hunt();
						r.drop = scfd_pkg::DROP_LEN;
					end else begin
						body_count = '0;
						phase_q    = S_DATA;
					end
				end
			end
			S_DATA: begin
				if (!keep_byte(b)) begin
					r.drop = scfd_pkg::DROP_OVF;
				end else begin
					body_count = body_count + 16'd1;
					if (body_count >= body_len)
						phase_q = S_SUM;
				end
			end
			S_SUM: begin
				if (b != sum_q) begin
					restart_hunt();
					r.drop = scfd_pkg::DROP_SUM;
				end else begin
					phase_q = S_TAIL;
				end
			end
			S_TAIL: begin
				if (b == end_q) begin
					r.done = 1'b1;
					for (int i = 0; i < scfd_pkg::ADDR_BYTES; i++) begin
						r.addr[8*i +: 8]  = shadow_store[1 + i];
						r.stamp[8*i +: 8] = shadow_store[scfd_pkg::HDR_BYTES + i];
					end
					r.ctrl = shadow_store[8];
					r.dev  = shadow_store[scfd_pkg::HDR_BYTES + 6];
					r.id   = {shadow_store[scfd_pkg::HDR_BYTES + 7],
					          shadow_store[scfd_pkg::HDR_BYTES + 8]};
					r.seq  = shadow_store[scfd_pkg::HDR_BYTES + 9];
					r.plen = 9'(body_len - scfd_pkg::DATA_HEAD);
				end else begin
					r.drop = scfd_pkg::DROP_END;
				end
				restart_hunt();
			end
			default: restart_hunt();
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic note_error(string msg);
		error_count++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
		if (got !== want)
			note_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin : result_check
		frame_result_t got;
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = frame_result_t'(m_tdata[scfd_pkg::RES_W-1:0]);
			if (parse_results_due.size() == 0) begin
				note_error("result transaction with no result pending");
			end else begin
				want = parse_results_due.pop_front();
				check_field("frame_done", got.done, want.done);
				check_field("drop_reason", got.drop, want.drop);
				check_field("station_addr", got.addr, want.addr);
				check_field("ctrl_code", got.ctrl, want.ctrl);
				check_field("time_stamp", got.stamp, want.stamp);
				check_field("device_kind", got.dev, want.dev);
				check_field("data_id", got.id, want.id);
				check_field("seq_num", got.seq, want.seq);
				check_field("body_bytes", got.plen, want.plen);
				check_field("read_data", got.rdata, want.rdata);
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// one input transaction; valid stays high until the caller idles
	task automatic send_item(logic op, logic [7:0] b, logic [8:0] idx);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(scfd_pkg::IN_W-17){1'b0}}, idx, b};
		do @(posedge clk); while (!s_tready);
		parse_results_due.push_back(parse_byte(op, b, idx));
		item_count++;
	endtask

	// read a written payload entry, or a position past the store
	task automatic send_read();
		logic [8:0] idx;
		if (store_fill > scfd_pkg::HDR_BYTES + scfd_pkg::DATA_HEAD && $urandom_range(7) != 0)
			idx = 9'($urandom_range(store_fill - scfd_pkg::HDR_BYTES -
			                        scfd_pkg::DATA_HEAD - 1));
		else
			idx = 9'($urandom_range(511, 491));
		send_item(scfd_pkg::OP_READ, 8'($urandom), idx);
	endtask

	function automatic logic [7:0] other_than_start();
		logic [7:0] b;
		do b = 8'($urandom); while (b == start_q);
		return b;
	endfunction

	function automatic logic [7:0] fill_byte(frame_fill_t fill);
		case (fill)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default:   return 8'($urandom);
		endcase
	endfunction

	function automatic int unsigned good_len();
		if ($urandom_range(29) == 0)
			return $urandom_range(max_len_q, scfd_pkg::DATA_HEAD);
		return $urandom_range((max_len_q < 40) ? max_len_q : 40, scfd_pkg::DATA_HEAD);
	endfunction

	function automatic int unsigned bad_len();
		if ($urandom_range(1) == 0)
			return $urandom_range(scfd_pkg::DATA_HEAD - 1);
		return $urandom_range(16'hFFFF, max_len_q + 1);
	endfunction

	// feed non-start bytes until the parser is back to hunting
	task automatic settle_to_hunt();
		while (phase_q != S_HUNT)
			send_item(scfd_pkg::OP_FEED, other_than_start(), 9'($urandom));
	endtask

	// one frame, cut short right after its flaw, reads mixed in
	task automatic send_frame(frame_flaw_t flaw, int unsigned len, frame_fill_t fill);
		logic [7:0] bytes_q [$];
		logic [7:0] csum;
		settle_to_hunt();
		bytes_q.push_back(start_q);
		repeat (scfd_pkg::ADDR_BYTES) bytes_q.push_back(fill_byte(fill));
		bytes_q.push_back((flaw == FLAW_START2) ? start_q ^ 8'($urandom_range(255, 1)) : start_q);
		if (flaw != FLAW_START2) begin
			bytes_q.push_back(fill_byte(fill));
			bytes_q.push_back(len[7:0]);
			bytes_q.push_back(len[15:8]);
			if (flaw != FLAW_LEN) begin
				repeat (len) bytes_q.push_back(fill_byte(fill));
				csum = '0;
				foreach (bytes_q[i])
					csum = csum + bytes_q[i];
				if (flaw == FLAW_SUM) begin
					bytes_q.push_back(csum ^ 8'($urandom_range(255, 1)));
				end else begin
					bytes_q.push_back(csum);
					bytes_q.push_back((flaw == FLAW_END) ?
						end_q ^ 8'($urandom_range(255, 1)) : end_q);
				end
			end
		end
		foreach (bytes_q[i]) begin
			if ($urandom_range(99) < 6)
				send_read();
			send_item(scfd_pkg::OP_FEED, bytes_q[i], 9'($urandom));
		end
	endtask

	task automatic send_noise(int unsigned count, bit stray_start);
		repeat (count) send_item(scfd_pkg::OP_FEED, other_than_start(), 9'($urandom));
		if (stray_start) begin
			send_item(scfd_pkg::OP_FEED, start_q, 9'($urandom));
			settle_to_hunt();
		end
	endtask

	task automatic drain_results();
		int unsigned waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (parse_results_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	// register writes, one per cycle, block idle
	task automatic apply_settings(logic [7:0] sb, logic [7:0] eb, logic [8:0] ml);
		cfg_we    <= 1'b1;
		cfg_addr  <= scfd_pkg::REG_START_BYTE;
		cfg_wdata <= {1'b0, sb};
		@(posedge clk);
		cfg_addr  <= scfd_pkg::REG_END_BYTE;
		cfg_wdata <= {1'b0, eb};
		@(posedge clk);
		cfg_addr  <= scfd_pkg::REG_MAX_LEN;
		cfg_wdata <= ml;
		@(posedge clk);
		cfg_we    <= 1'b0;
		start_q   = sb;
		end_q     = eb;
		max_len_q = ml;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// shortest frame, longest frame filling the whole store, ordinary frame
	task automatic test_good_frames();
		send_frame(FLAW_NONE, scfd_pkg::DATA_HEAD, FILL_ZERO);
		send_frame(FLAW_NONE, scfd_pkg::MAX_LEN_RST, FILL_ONES);
		send_frame(FLAW_NONE, 24, FILL_RANDOM);
	endtask

	// first and last payload entries, then positions past the store
	task automatic test_payload_reads();
		send_item(scfd_pkg::OP_READ, 8'h00, 9'd0);
		send_item(scfd_pkg::OP_READ, 8'hFF, 9'd490);
		send_item(scfd_pkg::OP_READ, 8'h00, 9'd491);
		send_item(scfd_pkg::OP_READ, 8'hFF, 9'h1FF);
	endtask

	// every drop reason that the default register settings allow; overflow cannot
	// arise since the longest frame accepted under them ends on the last store entry
	task automatic test_frame_drops();
		send_frame(FLAW_START2, scfd_pkg::DATA_HEAD, FILL_RANDOM);
		send_frame(FLAW_LEN, 0, FILL_RANDOM);
		send_frame(FLAW_LEN, scfd_pkg::DATA_HEAD - 1, FILL_RANDOM);
		send_frame(FLAW_LEN, scfd_pkg::MAX_LEN_RST + 1, FILL_RANDOM);
		send_frame(FLAW_LEN, 16'hFFFF, FILL_ONES);
		send_frame(FLAW_SUM, 12, FILL_RANDOM);
		send_frame(FLAW_END, 12, FILL_RANDOM);
	endtask

	// junk while hunting, and a stray start that runs into junk
	task automatic test_hunting_noise();
		send_noise(8, 1'b0);
		send_noise(2, 1'b1);
		send_frame(FLAW_NONE, scfd_pkg::DATA_HEAD, FILL_RANDOM);
	endtask

	task automatic test_random_traffic(int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		frame_flaw_t flaw;
		stop_at = item_count + quota;
		while (item_count < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				send_frame(FLAW_NONE, good_len(), FILL_RANDOM);
			end else if (pick < 80) begin
				flaw = frame_flaw_t'($urandom_range(FLAW_END, FLAW_START2));
				send_frame(flaw, (flaw == FLAW_LEN) ? bad_len() : good_len(), FILL_RANDOM);
			end else if (pick < 90) begin
				send_noise($urandom_range(6, 1), $urandom_range(3) == 0);
			end else begin
				repeat ($urandom_range(4, 1)) send_read();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_good_frames();
		test_payload_reads();
		test_frame_drops();
		test_hunting_noise();

		// defaults rewritten, no throttling
		drain_results();
		apply_settings(scfd_pkg::START_BYTE_RST, scfd_pkg::END_BYTE_RST,
		               scfd_pkg::MAX_LEN_RST);
		test_random_traffic(250);

		// low extremes, sender mostly idle
		drain_results();
		apply_settings(8'h00, 8'hFF, 9'(scfd_pkg::DATA_HEAD));
		send_gap_pct = 88;
		test_random_traffic(250);

		// high extremes, receiver mostly stalled
		drain_results();
		apply_settings(8'hFF, 8'h00, scfd_pkg::MAX_LEN_RST);
		send_gap_pct   = 0;
		recv_stall_pct = 88;
		test_random_traffic(250);

		// random settings, light throttling on both sides
		drain_results();
		apply_settings(8'($urandom), 8'($urandom),
		               9'($urandom_range(scfd_pkg::MAX_LEN_RST, scfd_pkg::DATA_HEAD)));
		send_gap_pct   = 11;
		recv_stall_pct = 11;
		test_random_traffic(250);

		drain_results();
		if (parse_results_due.size() != 0)
			note_error($sformatf("%0d results never arrived", parse_results_due.size()));
		if (error_count == 0)
			$display("PASS sum_checked_frame_deframer");
		else
			$display("FAIL sum_checked_frame_deframer");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL sum_checked_frame_deframer");
		$finish;
	end

endmodule

### files.f
rtl/scfd_pkg.sv
rtl/scfd_ram.sv
rtl/sum_checked_frame_deframer.sv
rtl/scfd_checker.sv
tb/sum_checked_frame_deframer_tb.sv
